@@ hdl/b2da_pkg.sv @@
// Shared types, constants and helpers for the binary to decimal ASCII converter.
// No dependencies.
package b2da_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int POS_W = 5;
	localparam int CHAR_W = 6;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CHAR_W-1:0] char_t;

	localparam char_t ASCII_ZERO = 6'd48;
	localparam char_t ASCII_NINE = 6'd57;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic dabble;
		logic skip;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic bit_last;
		logic top_zero;
		logic one_left;
		logic out_free;
	} sts_t;

	// Decimal digits needed for an unsigned value of w bits (1233/4096 ~ log10 2).
	function automatic int num_digits(input int w);
		return ((w * 1233) >> 12) + 1;
	endfunction

endpackage

@@ hdl/b2da_ctrl.sv @@
// Controller for the binary to decimal ASCII converter: sequences load,
// double-dabble, leading zero skip and digit emit. Depends on b2da_pkg.
module b2da_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  b2da_pkg::sts_t  sts,
	output b2da_pkg::cmd_t  cmd
);

	b2da_pkg::state_t state_q;
	b2da_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b2da_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			b2da_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = b2da_pkg::ST_CONV;
				end
			end
			b2da_pkg::ST_CONV: begin
				cmd.dabble = 1'b1;
				if (sts.bit_last) begin
					state_d = b2da_pkg::ST_SKIP;
				end
			end
			b2da_pkg::ST_SKIP: begin
				if (sts.top_zero && !sts.one_left) begin
					cmd.skip = 1'b1;
				end else begin
					state_d = b2da_pkg::ST_EMIT;
				end
			end
			b2da_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.one_left) begin
						state_d = b2da_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = b2da_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_load_to_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == b2da_pkg::ST_CONV)
		else $error("accepted transfer did not start conversion");
	a_conv_to_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == b2da_pkg::ST_CONV && sts.bit_last) |=> state_q == b2da_pkg::ST_SKIP)
		else $error("conversion did not end after last bit");
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.one_left) |=> state_q == b2da_pkg::ST_IDLE)
		else $error("final digit did not return to idle");
`endif

endmodule

@@ hdl/b2da_dp.sv @@
// Datapath for the binary to decimal ASCII converter: bit-serial double-dabble
// register, digit shifter and output register. Depends on b2da_pkg.
module b2da_dp #(
	parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF,
	parameter int NDIG        = b2da_pkg::num_digits(b2da_pkg::VALUE_WIDTH_DEF)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [VALUE_WIDTH-1:0] value,
	input  b2da_pkg::cmd_t         cmd,
	output b2da_pkg::sts_t         sts,
	output logic                   out_valid,
	input  logic                   out_stall,
	output b2da_pkg::char_t        digit_char,
	output b2da_pkg::pos_t         position,
	output logic                   last
);

	localparam int CW = $clog2(VALUE_WIDTH + 1);
	localparam int LW = $clog2(NDIG + 1);
	localparam int BW = 4 * NDIG;

	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BW-1:0]          bcd_q;
	logic [BW-1:0]          adj;
	logic [CW-1:0]          bitcnt_q;
	logic [LW-1:0]          left_q;
	b2da_pkg::pos_t         pos_q;
	logic [3:0]             top;
	logic                   out_valid_q;
	b2da_pkg::char_t        digit_char_q;
	b2da_pkg::pos_t         position_q;
	logic                   last_q;

	always_comb begin
		logic [3:0] dig;
		dig = '0;
		for (int i = 0; i < NDIG; i++) begin
			dig = bcd_q[4*i +: 4];
			adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
		end
	end

	assign top = bcd_q[BW-1 -: 4];

	assign sts.bit_last = (bitcnt_q == CW'(1));
	assign sts.top_zero = (top == 4'd0);
	assign sts.one_left = (left_q == LW'(1));
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q    <= value;
			bcd_q    <= '0;
			bitcnt_q <= CW'(VALUE_WIDTH);
			left_q   <= LW'(NDIG);
			pos_q    <= '0;
		end else if (cmd.dabble) begin
			{bcd_q, bin_q} <= {adj[BW-2:0], bin_q, 1'b0};
			bitcnt_q       <= bitcnt_q - CW'(1);
		end else if (cmd.skip || cmd.emit) begin
			bcd_q  <= {bcd_q[BW-5:0], 4'd0};
			left_q <= left_q - LW'(1);
			if (cmd.emit) begin
				pos_q <= pos_q + b2da_pkg::pos_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			digit_char_q <= b2da_pkg::ASCII_ZERO + b2da_pkg::char_t'(top);
			position_q   <= pos_q;
			last_q       <= sts.one_left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = digit_char_q;
	assign position   = position_q;
	assign last       = last_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (digit_char_q >= b2da_pkg::ASCII_ZERO &&
			digit_char_q <= b2da_pkg::ASCII_NINE))
		else $error("digit out of range");
	a_skip_keeps_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.skip |-> left_q > LW'(1))
		else $error("skip removed the final digit");
`endif

endmodule

@@ hdl/binary_to_decimal_ascii.sv @@
// Binary to decimal ASCII converter, top level.
// Input channel in_valid/in_stall carries value; output channel
// out_valid/out_stall carries one transfer per decimal digit, most
// significant first: digit_char (ASCII), position (0 = most significant)
// and last on the final digit. Leading zeros are dropped; zero gives "0".
// Bits of value above VALUE_WIDTH are ignored.
// Steps per item: a load, one double-dabble shift per bit of value (one bit
// per cycle through the shift register), a skip step per leading zero digit,
// a step to leave the skip state and an emit per digit, which waits while the
// output is stalled; skipped plus emitted digits always make NDIG. The first
// digit appears after the load, the shifts, the skips and the leave step.
// in_stall is low only while idle; a new value is taken while the final
// digit still waits in the output register.
// When the receiver stalls, the output register holds its digit and the
// controller waits before shifting out the next one.
// Reset (arst_n low) empties the output register and returns to idle.
// Depends on b2da_pkg, b2da_ctrl, b2da_dp.
module binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output b2da_pkg::char_t        digit_char,
	output b2da_pkg::pos_t         position,
	output logic                   last
);

	localparam int NDIG = b2da_pkg::num_digits(VALUE_WIDTH);

	b2da_pkg::cmd_t cmd;
	b2da_pkg::sts_t sts;

	b2da_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	b2da_dp #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NDIG        (NDIG)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.position   (position),
		.last       (last)
	);

endmodule
